// ===== design/lsr_pkg.sv =====
package lsr_pkg;

    localparam int TABLE_DEPTH       = 256;
    localparam int INDEX_W           = 8;
    localparam int COUNT_W           = 9;
    localparam int MAX_VARIABLES_DEF = 256;

    localparam logic [1:0] FUNC_SCAN       = 2'd0;
    localparam logic [1:0] FUNC_END_SCAN   = 2'd1;
    localparam logic [1:0] FUNC_RENAME     = 2'd2;
    localparam logic [1:0] FUNC_END_RENAME = 2'd3;

    localparam logic [1:0] OP_MOVE_IMM = 2'd0;
    localparam logic [1:0] OP_MOVE_VAR = 2'd1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_END_SCAN,
        ST_LEFT,
        ST_RIGHT,
        ST_DEST,
        ST_CONN,
        ST_CLEAR
    } lsr_state_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [1:0]         op_class;
        logic               has_left;
        logic               has_right;
        logic               has_dest;
        logic [INDEX_W-1:0] left_index;
        logic [INDEX_W-1:0] right_index;
        logic [INDEX_W-1:0] dest_index;
        logic               connector_valid;
        logic [INDEX_W-1:0] connector_index;
    } lsr_cmd_t;

    typedef struct packed {
        logic [INDEX_W-1:0] left_out;
        logic [INDEX_W-1:0] right_out;
        logic [INDEX_W-1:0] dest_out;
        logic [INDEX_W-1:0] connector_out;
        logic [1:0]         status;
    } lsr_result_t;

    typedef struct packed {
        logic               rd_en;
        logic [INDEX_W-1:0] rd_addr;
        logic               wr_en;
        logic [INDEX_W-1:0] wr_addr;
        logic [INDEX_W-1:0] wr_data;
        logic               clear;
    } lsr_table_ctl_t;

    typedef struct packed {
        logic scan;
        logic end_scan;
        logic set_written;
    } lsr_mark_ctl_t;

endpackage

// ===== design/local_ssa_variable_renamer.sv =====
// channel  | ports                      | transfer
// ---------+----------------------------+-------------------------------------
// command  | start, busy, cmd           | start && !busy at a rising edge
// result   | done, result               | done high for one cycle, no stall
// config   | cfg_write, cfg_data        | cfg_write at a rising edge
//
// rename runs LEFT, RIGHT, DEST; end rename CONN, CLEAR; scans SCAN/END_SCAN
// the rename table has one read port, so left and right lookups are issued
// one per cycle ahead of the destination update, the connector ahead of clear
// reset clears all marks and the table to identity at once, count to zero
// busy holds off the next command until its result is shown
module local_ssa_variable_renamer
    import lsr_pkg::*;
#(
    parameter int MAX_VARIABLES = MAX_VARIABLES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  lsr_cmd_t           cmd,
    output logic               busy,
    output logic               done,
    output lsr_result_t        result,
    input  logic               cfg_write,
    input  logic [COUNT_W-1:0] cfg_data
);

    lsr_table_ctl_t     tbl_ctl;
    lsr_mark_ctl_t      mark_ctl;
    lsr_cmd_t           cmd_held;
    logic [COUNT_W-1:0] count;
    logic [INDEX_W-1:0] rd_data;
    logic               dest_reuse;

    lsr_seq #(
        .MAX_VARIABLES (MAX_VARIABLES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .rd_data    (rd_data),
        .dest_reuse (dest_reuse),
        .busy       (busy),
        .done       (done),
        .result     (result),
        .tbl_ctl    (tbl_ctl),
        .mark_ctl   (mark_ctl),
        .cmd_held   (cmd_held),
        .count      (count)
    );

    lsr_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (tbl_ctl),
        .rd_data (rd_data)
    );

    lsr_marks u_marks (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mark_ctl),
        .cmd        (cmd_held),
        .count      (count),
        .dest_reuse (dest_reuse)
    );

endmodule

// ===== design/lsr_table.sv =====
module lsr_table
    import lsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lsr_table_ctl_t       ctl,
    output logic [INDEX_W-1:0]   rd_data
);

    logic [INDEX_W-1:0]     mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic [INDEX_W-1:0]     mem_data_reg;
    logic [INDEX_W-1:0]     addr_reg;
    logic                   hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        if (ctl.rd_en)
        begin
            mem_data_reg <= mem[ctl.rd_addr];
            addr_reg     <= ctl.rd_addr;
            hit_reg      <= valid_reg[ctl.rd_addr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.wr_en)
        begin
            valid_next[ctl.wr_addr] = 1'b1;
        end
        if (ctl.clear)
        begin
            valid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // entries never written since the last clear read as identity
    assign rd_data = hit_reg ? mem_data_reg : addr_reg;

endmodule

// ===== design/lsr_marks.sv =====
module lsr_marks
    import lsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lsr_mark_ctl_t      ctl,
    input  lsr_cmd_t           cmd,
    input  logic [COUNT_W-1:0] count,
    output logic               dest_reuse
);

    logic [TABLE_DEPTH-1:0] owned_reg;
    logic [TABLE_DEPTH-1:0] owned_next;
    logic [TABLE_DEPTH-1:0] used_reg;
    logic [TABLE_DEPTH-1:0] used_next;
    logic [TABLE_DEPTH-1:0] multi_reg;
    logic [TABLE_DEPTH-1:0] multi_next;
    logic [TABLE_DEPTH-1:0] written_reg;
    logic [TABLE_DEPTH-1:0] written_next;

    always_comb
    begin
        owned_next   = owned_reg;
        used_next    = used_reg;
        multi_next   = multi_reg;
        written_next = written_reg;
        if (ctl.scan)
        begin
            case (cmd.op_class)
                OP_MOVE_IMM:
                begin
                    owned_next[cmd.left_index] = 1'b1;
                    owned_next[cmd.dest_index] = 1'b1;
                end
                OP_MOVE_VAR:
                begin
                    owned_next[cmd.dest_index] = 1'b1;
                end
                default:
                begin
                    if (cmd.has_left)
                    begin
                        used_next[cmd.left_index] = 1'b1;
                    end
                    if (cmd.has_right)
                    begin
                        used_next[cmd.right_index] = 1'b1;
                    end
                end
            endcase
        end
        if (ctl.end_scan)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (used_reg[i] && !owned_reg[i] && (COUNT_W'(i) < count))
                begin
                    multi_next[i] = 1'b1;
                end
            end
            owned_next = '0;
            used_next  = '0;
        end
        if (ctl.set_written)
        begin
            written_next[cmd.dest_index] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owned_reg   <= '0;
            used_reg    <= '0;
            multi_reg   <= '0;
            written_reg <= '0;
        end
        else
        begin
            owned_reg   <= owned_next;
            used_reg    <= used_next;
            multi_reg   <= multi_next;
            written_reg <= written_next;
        end
    end

    assign dest_reuse = multi_reg[cmd.dest_index] | written_reg[cmd.dest_index];

endmodule

// ===== design/lsr_seq.sv =====
module lsr_seq
    import lsr_pkg::*;
#(
    parameter int MAX_VARIABLES = MAX_VARIABLES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  lsr_cmd_t           cmd,
    input  logic               cfg_write,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic [INDEX_W-1:0] rd_data,
    input  logic               dest_reuse,
    output logic               busy,
    output logic               done,
    output lsr_result_t        result,
    output lsr_table_ctl_t     tbl_ctl,
    output lsr_mark_ctl_t      mark_ctl,
    output lsr_cmd_t           cmd_held,
    output logic [COUNT_W-1:0] count
);

    localparam int CAP = (MAX_VARIABLES < TABLE_DEPTH) ? MAX_VARIABLES : TABLE_DEPTH;

    lsr_state_t         state_reg;
    lsr_state_t         state_next;
    lsr_cmd_t           cmd_reg;
    lsr_result_t        res_reg;
    lsr_result_t        res_next;
    logic               done_reg;
    logic               done_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.func)
                        FUNC_SCAN:     state_next = ST_SCAN;
                        FUNC_END_SCAN: state_next = ST_END_SCAN;
                        FUNC_RENAME:   state_next = ST_LEFT;
                        default:       state_next = ST_CONN;
                    endcase
                end
            end
            ST_LEFT:  state_next = ST_RIGHT;
            ST_RIGHT: state_next = ST_DEST;
            ST_CONN:  state_next = ST_CLEAR;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        res_next   = res_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        tbl_ctl    = '0;
        mark_ctl   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    res_next.left_out      = cmd.left_index;
                    res_next.right_out     = cmd.right_index;
                    res_next.dest_out      = cmd.dest_index;
                    res_next.connector_out = '0;
                    res_next.status        = STATUS_OK;
                end
            end
            ST_SCAN:
            begin
                mark_ctl.scan = 1'b1;
                done_next     = 1'b1;
            end
            ST_END_SCAN:
            begin
                mark_ctl.end_scan = 1'b1;
                done_next         = 1'b1;
            end
            ST_LEFT:
            begin
                tbl_ctl.rd_en   = 1'b1;
                tbl_ctl.rd_addr = cmd_reg.left_index;
            end
            ST_RIGHT:
            begin
                tbl_ctl.rd_en   = 1'b1;
                tbl_ctl.rd_addr = cmd_reg.right_index;
                if (cmd_reg.has_left)
                begin
                    if ({1'b0, cmd_reg.left_index} < count_reg)
                    begin
                        res_next.left_out = rd_data;
                    end
                    else
                    begin
                        res_next.status = STATUS_RANGE;
                    end
                end
            end
            ST_DEST:
            begin
                if (cmd_reg.has_right)
                begin
                    if ({1'b0, cmd_reg.right_index} < count_reg)
                    begin
                        res_next.right_out = rd_data;
                    end
                    else
                    begin
                        res_next.status = STATUS_RANGE;
                    end
                end
                if (cmd_reg.has_dest)
                begin
                    mark_ctl.set_written = 1'b1;
                    if (dest_reuse)
                    begin
                        if (count_reg >= COUNT_W'(CAP))
                        begin
                            res_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            tbl_ctl.wr_en     = 1'b1;
                            tbl_ctl.wr_addr   = cmd_reg.dest_index;
                            tbl_ctl.wr_data   = count_reg[INDEX_W-1:0];
                            res_next.dest_out = count_reg[INDEX_W-1:0];
                            count_next        = count_reg + COUNT_W'(1);
                        end
                    end
                end
                done_next = 1'b1;
            end
            ST_CONN:
            begin
                tbl_ctl.rd_en   = 1'b1;
                tbl_ctl.rd_addr = cmd_reg.connector_index;
            end
            ST_CLEAR:
            begin
                if (cmd_reg.connector_valid)
                begin
                    res_next.connector_out = rd_data;
                end
                tbl_ctl.clear = 1'b1;
                done_next     = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
        if (cfg_write)
        begin
            count_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if ((state_reg == ST_IDLE) && start)
        begin
            cmd_reg <= cmd;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign result   = res_reg;
    assign cmd_held = cmd_reg;
    assign count    = count_reg;

endmodule

// ===== design/lsr_checker.sv =====
module lsr_checker
    import lsr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input lsr_result_t        result
);

    // an accepted transaction occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // the result shows exactly when busy drops
    a_done_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $fell(busy))
        else $error("done without end of transaction");

    a_release_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("transaction ended without result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == STATUS_OK || result.status == STATUS_RANGE ||
                  result.status == STATUS_FULL))
        else $error("undefined status code");

endmodule

bind local_ssa_variable_renamer lsr_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .result    (result)
);
